/* hw/rtl/mtld_pkg.sv */
// Shared types, constants and the keystream step function for the meter
// telegram descrambler. No dependencies.
package mtld_pkg;

	localparam int FRAME_BYTES     = 30;
	localparam int SCRAMBLED_BYTES = 11;
	localparam int FIRST_SCRAMBLED = 17;
	localparam int LAST_SCRAMBLED  = FIRST_SCRAMBLED + SCRAMBLED_BYTES - 1;
	localparam int LAST_INDEX_BYTE = FIRST_SCRAMBLED + 4;
	localparam int POS_MAX         = 63;

	localparam logic [7:0]  HDR_LEN      = 8'h19;
	localparam logic [7:0]  HDR_CTRL     = 8'h44;
	localparam logic [7:0]  HDR_MFCT_LO  = 8'h30;
	localparam logic [7:0]  HDR_MFCT_HI  = 8'h4C;
	localparam logic [7:0]  HDR_CI       = 8'hA1;
	localparam logic [7:0]  HDR_UNIT     = 8'h13;
	localparam logic [7:0]  CHECK_VALUE  = 8'h4B;
	localparam logic [31:0] BASE_KEY_RST = 32'hDFD109E8;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_WANTED_ID = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_KEY  = 1'd1;

	typedef logic [5:0] pos_t;

	typedef struct packed {
		logic        frame_ok;
		logic        accepted;
		logic [23:0] status_bytes;
		logic [31:0] meter_index;
	} result_t;

	// Eight LFSR steps, feedback bit1^bit2^bit11^bit31 into bit 0
	function automatic logic [31:0] advance8(input logic [31:0] k_in);
		logic [31:0] k;
		logic        fb;
		k = k_in;
		for (int n = 0; n < 8; n++) begin
			fb = k[1] ^ k[2] ^ k[11] ^ k[31];
			k  = {k[30:0], fb};
		end
		return k;
	endfunction

endpackage

/* hw/rtl/meter_telegram_lfsr_decoder_unit.sv */
// Meter telegram descrambler top level: input beat register, frame core,
// result register and configuration registers. Depends on mtld_pkg and
// mtld_frame_core.
// A telegram's last byte goes through the input beat register and its result
// through the result register to m_tdata. Throughput: one byte per cycle; the
// input stalls only while a last byte waits behind an untaken result.
// Reset: arst_n clears frame state and handshakes, wanted_id to 0 and
// base_key to 0xDFD109E8.
module meter_telegram_lfsr_decoder_unit import mtld_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // rx_byte
	input  logic                  s_tlast,   // frame_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [63:0]           m_tdata,   // frame_ok, accepted, status_bytes[23:0],
	                                         // meter_index[31:0], zero fill
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res;
	logic [47:0] wanted_id_q;
	logic [31:0] base_key_q;
	logic        out_free;
	logic        proc;

	assign out_free = !out_valid_q || m_tready;
	// a last byte waits until the result register is free
	assign proc     = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_id_q <= '0;
			base_key_q  <= BASE_KEY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WANTED_ID: wanted_id_q <= cfg_data;
				CFG_BASE_KEY:  base_key_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (out_free)
				out_valid_q <= proc && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (proc && last_s1)
			res_q <= res;
	end

	mtld_frame_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (proc),
		.rx_byte   (byte_s1),
		.frame_end (last_s1),
		.wanted_id (wanted_id_q),
		.base_key  (base_key_q),
		.res       (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, res_q.meter_index, res_q.status_bytes,
		res_q.accepted, res_q.frame_ok};

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |=> out_valid_q)
		else $error("last byte processed without a result beat");

	a_accept_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!res_q.accepted || res_q.frame_ok))
		else $error("accepted set on a failed frame");

	a_failed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.frame_ok) |->
		(res_q.status_bytes == '0 && res_q.meter_index == '0))
		else $error("failed frame carries nonzero fields");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !(proc && last_s1))
		else $error("result register overwritten while stalled");

endmodule

/* hw/rtl/mtld_frame_core.sv */
// Per-byte frame state: header checks, address match, key seed folding,
// descrambling and result assembly. Depends on mtld_pkg.
module mtld_frame_core import mtld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	input  logic [47:0] wanted_id,
	input  logic [31:0] base_key,
	output result_t     res
);

	pos_t        pos_q;
	logic [31:0] key_q;
	logic [23:0] status_q;
	logic [31:0] index_q;
	logic        fault_q;
	logic        addr_eq_q;

	logic [31:0] key_v;
	logic [23:0] status_v;
	logic [31:0] index_v;
	logic        fault_v;
	logic        addr_eq_v;
	logic [7:0]  wid_byte;
	logic [7:0]  want_hdr;
	logic        hdr_chk;
	logic [7:0]  plain;
	logic [1:0]  isel;
	logic        ok;

	always_comb begin
		key_v     = (pos_q == '0) ? base_key : key_q;
		status_v  = status_q;
		index_v   = index_q;
		fault_v   = fault_q;
		addr_eq_v = addr_eq_q;
		wid_byte  = '0;
		want_hdr  = '0;
		hdr_chk   = 1'b0;
		plain     = '0;
		isel      = 2'(pos_q - 6'(FIRST_SCRAMBLED + 1));

		// fold header words into the seed, big-endian
		case (pos_q)
			6'd2, 6'd6, 6'd12:  key_v[31:24] = key_v[31:24] ^ rx_byte;
			6'd3, 6'd7, 6'd13:  key_v[23:16] = key_v[23:16] ^ rx_byte;
			6'd4, 6'd8, 6'd14:  key_v[15:8]  = key_v[15:8] ^ rx_byte;
			6'd5, 6'd9, 6'd15:  key_v[7:0]   = key_v[7:0] ^ rx_byte;
			default: ;
		endcase

		case (pos_q)
			6'd4:    wid_byte = wanted_id[7:0];
			6'd5:    wid_byte = wanted_id[15:8];
			6'd6:    wid_byte = wanted_id[23:16];
			6'd7:    wid_byte = wanted_id[31:24];
			6'd8:    wid_byte = wanted_id[39:32];
			6'd9:    wid_byte = wanted_id[47:40];
			default: wid_byte = rx_byte;
		endcase
		if (wid_byte != rx_byte)
			addr_eq_v = 1'b0;

		case (pos_q)
			6'd0:  begin hdr_chk = 1'b1; want_hdr = HDR_LEN;     end
			6'd1:  begin hdr_chk = 1'b1; want_hdr = HDR_CTRL;    end
			6'd2:  begin hdr_chk = 1'b1; want_hdr = HDR_MFCT_LO; end
			6'd3:  begin hdr_chk = 1'b1; want_hdr = HDR_MFCT_HI; end
			6'd12: begin hdr_chk = 1'b1; want_hdr = HDR_CI;      end
			6'd16: begin hdr_chk = 1'b1; want_hdr = HDR_UNIT;    end
			default: ;
		endcase
		if (hdr_chk && rx_byte != want_hdr)
			fault_v = 1'b1;

		case (pos_q)
			6'd13:   status_v[7:0]   = status_v[7:0] | rx_byte;
			6'd14:   status_v[15:8]  = status_v[15:8] | rx_byte;
			6'd15:   status_v[23:16] = status_v[23:16] | rx_byte;
			default: ;
		endcase

		if (pos_q >= 6'(FIRST_SCRAMBLED) && pos_q <= 6'(LAST_SCRAMBLED)) begin
			key_v = advance8(key_v);
			plain = rx_byte ^ key_v[7:0];
			if (pos_q == 6'(FIRST_SCRAMBLED)) begin
				if (plain != CHECK_VALUE)
					fault_v = 1'b1;
			end else if (pos_q <= 6'(LAST_INDEX_BYTE)) begin
				index_v[{isel, 3'b000} +: 8] = index_v[{isel, 3'b000} +: 8] | plain;
			end
		end

		ok               = !fault_v && pos_q == 6'(FRAME_BYTES - 1);
		res.frame_ok     = ok;
		res.accepted     = ok && addr_eq_v;
		res.status_bytes = ok ? status_v : '0;
		res.meter_index  = ok ? index_v : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			key_q     <= '0;
			status_q  <= '0;
			index_q   <= '0;
			fault_q   <= 1'b0;
			addr_eq_q <= 1'b1;
		end else if (en) begin
			if (frame_end) begin
				pos_q     <= '0;
				key_q     <= '0;
				status_q  <= '0;
				index_q   <= '0;
				fault_q   <= 1'b0;
				addr_eq_q <= 1'b1;
			end else begin
				if (pos_q != 6'(POS_MAX))
					pos_q <= pos_q + 6'd1;
				key_q     <= key_v;
				status_q  <= status_v;
				index_q   <= index_v;
				fault_q   <= fault_v;
				addr_eq_q <= addr_eq_v;
			end
		end
	end

endmodule
